// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg - shared definitions for the thread slot scheduler
// Slot table sizing, request/status codes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned STACK_BYTES = 8192;

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned OFF_W   = $clog2(SLOTS * STACK_BYTES + 1);
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OSLOT_W = 2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [OFF_W-1:0]  off_t;

  localparam slot_idx_t SLOT_LAST = slot_idx_t'(SLOTS - 1);
  localparam off_t      STACK_OFF = off_t'(STACK_BYTES);

  // stack tops are rounded down to 16 bytes
  localparam logic [ADDR_W-1:0] ALIGN_MASK = 64'd15;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_RUNNABLE = 2'd2
  } slot_state_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_YIELD  = 2'd1,
    REQ_EXIT   = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FREE     = 2'd1,
    STAT_NO_RUNNABLE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic start;   // capture request word, arm the scan
    logic step;    // examine one slot
    logic finish;  // commit state, load result word
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

  function automatic slot_idx_t slot_inc(slot_idx_t s);
    slot_idx_t r;
    if (s == SLOT_LAST) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  // slot numbers leave the block as 2-bit fields (wrap for larger tables)
  function automatic logic [OSLOT_W-1:0] slot_field(slot_idx_t s);
    logic [SLOT_W+OSLOT_W-1:0] wide;
    wide = {{OSLOT_W{1'b0}}, s};
    return wide[OSLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl - scheduler sequencer
// Walks each request through capture, slot scan and commit; owns the
// handshakes and the result-valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire rrts_pkg::dp_stat_t stat_i,
  output rrts_pkg::dp_cmd_t       cmd_o
);
  import rrts_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // result register can take a new word if empty or draining this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (in_valid_i) begin
          state_d = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = CTRL_FINISH;
        end
      end
      CTRL_FINISH: begin
        if (out_free) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      CTRL_SCAN: begin
        cmd_o.step   = 1'b1;
      end
      CTRL_FINISH: begin
        cmd_o.finish = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// rrts_dp - scheduler datapath
// Slot table, current slot, stack base, one-slot-per-cycle scanner and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rrts_pkg::dp_cmd_t              cmd_i,
  output rrts_pkg::dp_stat_t                  stat_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrts_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  wire logic [rrts_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [rrts_pkg::ADDR_W-1:0]    entry_address_i,
  output logic      [rrts_pkg::STAT_W-1:0]    status_o,
  output logic                                switched_o,
  output logic      [rrts_pkg::OSLOT_W-1:0]   prev_slot_o,
  output logic      [rrts_pkg::OSLOT_W-1:0]   next_slot_o,
  output logic      [rrts_pkg::ADDR_W-1:0]    stack_top_o,
  output logic      [rrts_pkg::ADDR_W-1:0]    start_address_o
);
  import rrts_pkg::*;

  // architectural state
  slot_state_e        slot_q [SLOTS];
  slot_state_e        slot_d [SLOTS];
  slot_idx_t          cur_q, cur_d;
  logic [ADDR_W-1:0]  base_q;

  // captured request
  logic [REQ_W-1:0]   req_q;
  logic [ADDR_W-1:0]  entry_q;

  // scanner
  slot_idx_t          ptr_q, cnt_q;
  off_t               off_q;
  logic               hit_q;
  slot_idx_t          found_q;
  off_t               found_off_q;

  // result word
  logic [STAT_W-1:0]  res_status_q, res_status_d;
  logic               res_switched_q, res_switched_d;
  logic [OSLOT_W-1:0] res_prev_q, res_next_q;
  logic [OSLOT_W-1:0] res_prev_d, res_next_d;
  logic [ADDR_W-1:0]  res_top_q, res_start_q;
  logic [ADDR_W-1:0]  res_top_d, res_start_d;

  slot_state_e        eff;
  logic               match, last, is_nop;
  logic [ADDR_W-1:0]  top_sum;

  // ---- scan: one slot per step ----
  always_comb begin
    eff    = slot_q[ptr_q];
    match  = 1'b0;
    is_nop = 1'b0;
    unique case (req_q)
      REQ_CREATE: begin
        match = (eff == SLOT_FREE);
      end
      REQ_YIELD, REQ_EXIT: begin
        // current slot is seen with its post-request state, checked last
        if (ptr_q == cur_q) begin
          eff = (req_q == REQ_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
        end
        match = (eff == SLOT_RUNNABLE);
      end
      default: begin
        is_nop = 1'b1;
      end
    endcase
  end

  assign last             = (cnt_q == SLOT_LAST);
  assign stat_o.scan_done = match || last || is_nop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q   <= req_type_i;
      entry_q <= entry_address_i;
      cnt_q   <= '0;
      off_q   <= STACK_OFF;
      if (req_type_i == REQ_CREATE) begin
        ptr_q <= '0;
      end else begin
        ptr_q <= slot_inc(cur_q);
      end
    end else if (cmd_i.step) begin
      hit_q       <= match && !is_nop;
      found_q     <= ptr_q;
      found_off_q <= off_q;
      ptr_q       <= slot_inc(ptr_q);
      cnt_q       <= cnt_q + 1'b1;
      off_q       <= off_q + STACK_OFF;
    end
  end

  // ---- commit ----
  assign top_sum = (base_q + {{(ADDR_W-OFF_W){1'b0}}, found_off_q}) & ~ALIGN_MASK;

  always_comb begin
    slot_d = slot_q;
    cur_d  = cur_q;
    if (cmd_i.finish && hit_q) begin
      unique case (req_q)
        REQ_CREATE: begin
          slot_d[found_q] = SLOT_RUNNABLE;
        end
        REQ_YIELD, REQ_EXIT: begin
          slot_d[cur_q]   = (req_q == REQ_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
          slot_d[found_q] = SLOT_RUNNING;
          cur_d           = found_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        slot_q[i] <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
      end
      cur_q  <= '0;
      base_q <= '0;
    end else begin
      slot_q <= slot_d;
      cur_q  <= cur_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    res_prev_d     = slot_field(cur_q);
    res_next_d     = slot_field(cur_q);
    res_status_d   = STAT_OK;
    res_switched_d = 1'b0;
    res_top_d      = '0;
    res_start_d    = '0;
    unique case (req_q)
      REQ_CREATE: begin
        if (hit_q) begin
          res_next_d  = slot_field(found_q);
          res_top_d   = top_sum;
          res_start_d = entry_q;
        end else begin
          res_status_d = STAT_NO_FREE;
        end
      end
      REQ_YIELD, REQ_EXIT: begin
        if (hit_q) begin
          res_next_d     = slot_field(found_q);
          res_switched_d = (found_q != cur_q);
        end else begin
          res_status_d = STAT_NO_RUNNABLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_prev_q     <= res_prev_d;
      res_next_q     <= res_next_d;
      res_status_q   <= res_status_d;
      res_switched_q <= res_switched_d;
      res_top_q      <= res_top_d;
      res_start_q    <= res_start_d;
    end
  end

  assign status_o        = res_status_q;
  assign switched_o      = res_switched_q;
  assign prev_slot_o     = res_prev_q;
  assign next_slot_o     = res_next_q;
  assign stack_top_o     = res_top_q;
  assign start_address_o = res_start_q;

endmodule

`default_nettype wire

// ===== rtl/round_robin_thread_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler - thread slot allocator and switcher
// Create / yield / exit requests over a small slot table, round-robin pick.
// ----------------------------------------------------------------------------
// A request word's result word is presented once the scanner has examined
// n (1..SLOTS) slots, one per cycle, and the output register is free to
// load it: create stops at the lowest free slot, yield and exit at the first
// runnable slot after the current one (current checked last). Unused request
// code three ends the scan at its first step. The block takes one request at
// a time; a finished result waits in an output register, and the input is
// ready again as soon as that register has been loaded. Errors leave all
// state untouched.
// The stack base register may be written only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_slot_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrts_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rrts_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [rrts_pkg::ADDR_W-1:0]   entry_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rrts_pkg::STAT_W-1:0]   status_o,
  output logic                               switched_o,
  output logic      [rrts_pkg::OSLOT_W-1:0]  prev_slot_o,
  output logic      [rrts_pkg::OSLOT_W-1:0]  next_slot_o,
  output logic      [rrts_pkg::ADDR_W-1:0]   stack_top_o,
  output logic      [rrts_pkg::ADDR_W-1:0]   start_address_o
);
  import rrts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rrts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .entry_address_i (entry_address_i),
    .status_o        (status_o),
    .switched_o      (switched_o),
    .prev_slot_o     (prev_slot_o),
    .next_slot_o     (next_slot_o),
    .stack_top_o     (stack_top_o),
    .start_address_o (start_address_o)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - round-robin thread slot scheduler regression
// Drives create/yield/exit request words through the valid/ready input,
// predicts every result word from a local copy of the slot table, current
// slot and stack base, and compares each returned word field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 200000;
  localparam int unsigned      REPORT_CAP  = 40;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic               switched;
    logic [OSLOT_W-1:0] prev_slot;
    logic [OSLOT_W-1:0] next_slot;
    logic [ADDR_W-1:0]  stack_top;
    logic [ADDR_W-1:0]  start_address;
  } sched_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [REQ_W-1:0]   req_type_i      = '0;
  logic [ADDR_W-1:0]  entry_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [STAT_W-1:0]  status_o;
  logic               switched_o;
  logic [OSLOT_W-1:0] prev_slot_o;
  logic [OSLOT_W-1:0] next_slot_o;
  logic [ADDR_W-1:0]  stack_top_o;
  logic [ADDR_W-1:0]  start_address_o;

  // scheduler mirror
  slot_state_e       slot_table [SLOTS];
  int unsigned       cur_slot;
  logic [ADDR_W-1:0] stack_base;

  sched_result_t pending_results[$];
  sched_result_t want;
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;
  int unsigned   ready_hold  = 0;
  bit            idle_on     = 1'b0;

  round_robin_thread_slot_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .entry_address_i (entry_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .switched_o      (switched_o),
    .prev_slot_o     (prev_slot_o),
    .next_slot_o     (next_slot_o),
    .stack_top_o     (stack_top_o),
    .start_address_o (start_address_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
    end
  endtask

  // Predicts the result word of one request and updates the mirror.
  function automatic sched_result_t schedule_request(input logic [REQ_W-1:0] req,
                                                     input logic [ADDR_W-1:0] entry);
    sched_result_t r;
    int unsigned   s;
    int unsigned   i;
    int unsigned   found;
    bit            hit;
    slot_state_e   saved;
    r.status        = STAT_OK;
    r.switched      = 1'b0;
    r.prev_slot     = OSLOT_W'(cur_slot);
    r.next_slot     = OSLOT_W'(cur_slot);
    r.stack_top     = '0;
    r.start_address = '0;
    hit   = 1'b0;
    found = cur_slot;
    case (req)
      REQ_CREATE: begin
        for (s = 0; s < SLOTS; s++) begin
          if (!hit && slot_table[s] == SLOT_FREE) begin
            hit   = 1'b1;
            found = s;
          end
        end
        if (!hit) begin
          r.status = STAT_NO_FREE;
        end else begin
          slot_table[found] = SLOT_RUNNABLE;
          r.next_slot       = OSLOT_W'(found);
          r.stack_top       = (stack_base + 64'(found + 1) * 64'(STACK_BYTES)) & ~64'd15;
          r.start_address   = entry;
        end
      end
      REQ_YIELD, REQ_EXIT: begin
        saved = slot_table[cur_slot];
        slot_table[cur_slot] = (req == REQ_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
        // scan starts after current slot, current one checked last
        s = cur_slot;
        for (i = 0; i < SLOTS; i++) begin
          s = (s + 1) % SLOTS;
          if (!hit && slot_table[s] == SLOT_RUNNABLE) begin
            hit   = 1'b1;
            found = s;
          end
        end
        if (!hit) begin
          slot_table[cur_slot] = saved;
          r.status = STAT_NO_RUNNABLE;
        end else begin
          slot_table[found] = SLOT_RUNNING;
          r.switched  = (found != cur_slot);
          r.next_slot = OSLOT_W'(found);
          cur_slot    = found;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // result word checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("switched", 64'(switched_o), 64'(want.switched));
        check_field("prev_slot", 64'(prev_slot_o), 64'(want.prev_slot));
        check_field("next_slot", 64'(next_slot_o), 64'(want.next_slot));
        check_field("stack_top", stack_top_o, want.stack_top);
        check_field("start_address", start_address_o, want.start_address);
      end
    end
  end

  // output back-pressure in random bursts
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold  = $urandom_range(1, 10) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Called and returns at a falling edge; valid is low on return.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] entry);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    req_type_i      = req;
    entry_address_i = entry;
    in_valid_i      = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_results.push_back(schedule_request(req, entry));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_stack_base(input logic [ADDR_W-1:0] value);
    wait_drained();
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    stack_base  = value;
  endtask

  function automatic logic [REQ_W-1:0] pick_request();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 38) return REQ_CREATE;
    if (w < 68) return REQ_YIELD;
    if (w < 95) return REQ_EXIT;
    return REQ_UNUSED;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_entry();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // empty scans, full table, round-robin switching and both error codes
  task automatic test_directed_scheduling();
    send_request(REQ_YIELD, '0);        // only the current slot is runnable
    send_request(REQ_EXIT, '1);         // nothing else runnable
    send_request(REQ_UNUSED, '1);
    send_request(REQ_CREATE, '0);
    send_request(REQ_CREATE, '1);
    send_request(REQ_CREATE, 64'h8000_0000_0000_0001);
    send_request(REQ_CREATE, 64'h5555_5555_5555_5555);  // table full
    send_request(REQ_YIELD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(REQ_YIELD, '0);
    send_request(REQ_EXIT, '0);
    send_request(REQ_CREATE, 64'h0123_4567_89AB_CDEF);
    send_request(REQ_EXIT, '0);
    send_request(REQ_EXIT, '0);
    send_request(REQ_EXIT, '0);
    send_request(REQ_EXIT, '0);
  endtask

  // stack tops that wrap past 2^64 and an unaligned base
  task automatic test_stack_base_extremes();
    write_stack_base('1);
    send_request(REQ_CREATE, 64'hFEDC_BA98_7654_3210);
    send_request(REQ_CREATE, '1);
    send_request(REQ_CREATE, '0);
    write_stack_base(64'h0000_0000_0000_0007);
    send_request(REQ_EXIT, '0);
    send_request(REQ_CREATE, 64'h0000_0000_0000_0010);
    send_request(REQ_YIELD, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input logic [ADDR_W-1:0] base, input bit idle);
    int unsigned n;
    write_stack_base(base);
    idle_on = idle;
    for (n = 0; n < count; n++) begin
      send_request(pick_request(), pick_entry());
    end
    wait_drained();
  endtask

  initial begin
    int unsigned s;
    for (s = 0; s < SLOTS; s++) slot_table[s] = SLOT_FREE;
    slot_table[0] = SLOT_RUNNING;
    cur_slot   = 0;
    stack_base = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_on = 1'b1;
    test_directed_scheduling();
    test_stack_base_extremes();
    test_random_traffic(110, {$urandom, $urandom}, 1'b1);
    test_random_traffic(110, 64'hFFFF_FFFF_FFFF_E000, 1'b1);
    test_random_traffic(110, '0, 1'b0);
    test_random_traffic(110, {$urandom, $urandom}, 1'b1);
    test_random_traffic(110, 64'h0000_0000_0000_0009, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
